// ===== src/tsc_pkg.sv =====
// Shared types and constants of the TSC mass assignment block.
package tsc_pkg;

  localparam int KIND_W   = 2;
  localparam int POS_W    = 32;
  localparam int CIDX_W   = 18;
  localparam int GS_W     = 7;
  localparam int SCALE_W  = 32;
  localparam int MASS_W   = 24;
  localparam int DENS_W   = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int GS_MIN   = 3;

  localparam logic [GS_W-1:0]    GS_RST    = 7'd64;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd65536;
  localparam logic [MASS_W-1:0]  MASS_RST  = 24'd65536;
  localparam logic [DENS_W-1:0]  DENS_MAX  = {DENS_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_DEPOSIT  = 2'd0,
    KIND_READ     = 2'd1,
    KIND_READ_CLR = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_CELL_SCALE = 2'd1,
    REG_PART_MASS  = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_CELLS,
    ST_ACCUM,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_DATA
  } state_t;

endpackage

// ===== src/tsc_if.sv =====
// Valid/ready channel interfaces of the TSC block: input, result and configuration.
interface tsc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tsc_pkg::KIND_W-1:0]   kind;
  logic [tsc_pkg::POS_W-1:0]    pos_x;
  logic [tsc_pkg::POS_W-1:0]    pos_y;
  logic [tsc_pkg::POS_W-1:0]    pos_z;
  logic [tsc_pkg::CIDX_W-1:0]   cell_index;
  modport source (output valid, kind, pos_x, pos_y, pos_z, cell_index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, cell_index, output ready);
endinterface

interface tsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tsc_pkg::DENS_W-1:0]   density;
  logic                         overflowed;
  modport source (output valid, density, overflowed, input ready);
  modport sink   (input valid, density, overflowed, output ready);
endinterface

interface tsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsc_pkg::CFG_IDX_W-1:0]   index;
  logic [tsc_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tsc_mass_assignment_3d.sv =====
// Top level of the TSC mass assignment block: sequencer, weight setup and density store RMW.
//
//  channel  | dir | transaction                          | handshake
//  ---------+-----+--------------------------------------+-------------
//  in_ch    | in  | kind, pos_x/y/z, cell_index          | valid/ready
//  out_ch   | out | density, overflowed (reads only)     | valid/ready
//  cfg_ch   | in  | index, data register write           | valid/ready
//
// A deposit steps through a multiply, a bit-serial remainder by the grid size, a cell
// step, 27 store updates (one read-modify-write per cycle on the store's single write
// port) and a drain of the update pipeline.
// A read issues, then waits in its data state for the result register to free up.
// After reset the store is cleared one cell per cycle, all GRID_MAX**3 cells (262144 at
// the default); in_ch is held off meanwhile, cfg_ch is always ready.
module tsc_mass_assignment_3d #(
  parameter int GRID_MAX  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tsc_in_if.sink     in_ch,
  tsc_out_if.source  out_ch,
  tsc_cfg_if.sink    cfg_ch
);

  localparam int F      = FRAC_BITS;
  localparam int DEPTH  = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = (AW > tsc_pkg::CIDX_W) ? AW + 1 : tsc_pkg::CIDX_W + 1;
  localparam int CW     = $clog2(GRID_MAX);
  localparam int NW     = $clog2(GRID_MAX + 1);
  localparam int PW     = tsc_pkg::POS_W + tsc_pkg::SCALE_W;
  localparam int QW     = PW - 2 * F;
  localparam int SW     = $clog2(QW);
  localparam int WW     = F + 1;
  localparam int ADD_W  = tsc_pkg::MASS_W + WW - F;
  localparam int SUM_W  = tsc_pkg::DENS_W + 1;

  // Configuration registers
  logic [tsc_pkg::GS_W-1:0]    grid_size_r;
  logic [tsc_pkg::SCALE_W-1:0] cell_scale_r;
  logic [tsc_pkg::MASS_W-1:0]  mass_r;

  // Control state
  tsc_pkg::state_t state_r, state_nxt;
  logic [AW:0]     clr_cnt_r;
  logic [SW-1:0]   step_r;
  logic [1:0]      a_r, b_r, c_r;
  logic            v1_r, v2_r, v3_r;
  logic            flag_r;
  logic            out_valid_r;

  // Payload registers
  tsc_pkg::kind_t              kind_r;
  logic [tsc_pkg::CIDX_W-1:0]  cidx_r;
  logic [tsc_pkg::POS_W-1:0]   pos_r [3];
  logic [PW-1:0]               prod_r [3];
  logic [QW-1:0]               q_r [3];
  logic [NW-1:0]               rem_r [3];
  logic [WW-1:0]               wlo_r [3];
  logic [WW-1:0]               whi_r [3];
  logic [WW-1:0]               wx_r [3], wy_r [3], wz_r [3];
  logic [CW-1:0]               cx_r [3], cy_r [3], cz_r [3];
  logic [WW-1:0]               wxy_r, wz1_r, wxyz_r;
  logic [ADD_W-1:0]            add_r;
  logic [AW-1:0]               addr1_r, addr2_r, addr3_r;
  logic [tsc_pkg::DENS_W-1:0]  out_density_r;
  logic                        out_ovf_r;

  // Combinational helpers
  logic [NW-1:0]               n_eff;
  logic [XW-1:0]               cidx_ext;
  logic                        cidx_ok;
  logic                        in_acc;
  logic                        out_free;
  logic                        issue_last;
  logic [AW-1:0]               issue_addr;
  logic [2*WW-1:0]             m1, m2;
  logic [tsc_pkg::MASS_W+WW-1:0] m3;
  logic [SUM_W-1:0]            sum;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tsc_pkg::DENS_W-1:0]  ram_wdata, ram_rdata;
  logic [NW:0]                 rem_step [3];
  logic [2*WW-1:0]             rsq [3], fsq [3];
  logic [WW-1:0]               rfrac [3];

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cidx_ext = XW'(cidx_r);
  assign cidx_ok  = cidx_ext < XW'(DEPTH);
  assign issue_last = (a_r == 2'd2) && (b_r == 2'd2) && (c_r == 2'd2);

  // Clamp the grid size to the supported range
  always_comb begin
    if (grid_size_r < tsc_pkg::GS_W'(tsc_pkg::GS_MIN)) begin
      n_eff = NW'(tsc_pkg::GS_MIN);
    end else if (int'(grid_size_r) > GRID_MAX) begin
      n_eff = NW'(GRID_MAX);
    end else begin
      n_eff = NW'(grid_size_r);
    end
  end

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r  <= tsc_pkg::GS_RST;
      cell_scale_r <= tsc_pkg::SCALE_RST;
      mass_r       <= tsc_pkg::MASS_RST;
    end else if (cfg_ch.valid) begin
      case (tsc_pkg::cfg_reg_t'(cfg_ch.index))
        tsc_pkg::REG_GRID_SIZE:  grid_size_r  <= cfg_ch.data[tsc_pkg::GS_W-1:0];
        tsc_pkg::REG_CELL_SCALE: cell_scale_r <= cfg_ch.data[tsc_pkg::SCALE_W-1:0];
        tsc_pkg::REG_PART_MASS:  mass_r       <= cfg_ch.data[tsc_pkg::MASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == (AW+1)'(DEPTH - 1)) state_nxt = tsc_pkg::ST_IDLE;
      end
      tsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (tsc_pkg::kind_t'(in_ch.kind))
            tsc_pkg::KIND_DEPOSIT:  state_nxt = tsc_pkg::ST_MUL;
            tsc_pkg::KIND_READ,
            tsc_pkg::KIND_READ_CLR: state_nxt = tsc_pkg::ST_RD_ISSUE;
            default:                state_nxt = tsc_pkg::ST_IDLE;
          endcase
        end
      end
      tsc_pkg::ST_MUL:      state_nxt = tsc_pkg::ST_MOD;
      tsc_pkg::ST_MOD: begin
        if (step_r == SW'(QW - 1)) state_nxt = tsc_pkg::ST_CELLS;
      end
      tsc_pkg::ST_CELLS:    state_nxt = tsc_pkg::ST_ACCUM;
      tsc_pkg::ST_ACCUM: begin
        if (issue_last) state_nxt = tsc_pkg::ST_DRAIN;
      end
      tsc_pkg::ST_DRAIN: begin
        if (!v1_r && !v2_r && !v3_r) state_nxt = tsc_pkg::ST_IDLE;
      end
      tsc_pkg::ST_RD_ISSUE: state_nxt = tsc_pkg::ST_RD_DATA;
      tsc_pkg::ST_RD_DATA: begin
        if (out_free) state_nxt = tsc_pkg::ST_IDLE;
      end
      default:              state_nxt = tsc_pkg::ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == tsc_pkg::ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsc_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= '0;
      a_r         <= '0;
      b_r         <= '0;
      c_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tsc_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      step_r <= (state_r == tsc_pkg::ST_MOD) ? step_r + 1'b1 : '0;
      // Advance the 27-point neighborhood walk, x fastest
      if (state_r == tsc_pkg::ST_ACCUM) begin
        a_r <= (a_r == 2'd2) ? 2'd0 : a_r + 2'd1;
        if (a_r == 2'd2) begin
          b_r <= (b_r == 2'd2) ? 2'd0 : b_r + 2'd1;
          if (b_r == 2'd2) c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        end
      end
      v1_r <= (state_r == tsc_pkg::ST_ACCUM);
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r && sum > SUM_W'(tsc_pkg::DENS_MAX)) flag_r <= 1'b1;
      // Hold the result until taken
      if (state_r == tsc_pkg::ST_RD_DATA && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-axis weights and bit-serial remainder
  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign rem_step[k] = {rem_r[k], q_r[k][QW-1]};
    assign rfrac[k]    = WW'(1 << F) - WW'(prod_r[k][2*F-1:F]);
    assign rsq[k]      = rfrac[k] * rfrac[k];
    assign fsq[k]      = WW'(prod_r[k][2*F-1:F]) * WW'(prod_r[k][2*F-1:F]);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= tsc_pkg::kind_t'(in_ch.kind);
      cidx_r   <= in_ch.cell_index;
      pos_r[0] <= in_ch.pos_x;
      pos_r[1] <= in_ch.pos_y;
      pos_r[2] <= in_ch.pos_z;
    end
    for (int k = 0; k < 3; k++) begin
      if (state_r == tsc_pkg::ST_MUL) begin
        prod_r[k] <= PW'(pos_r[k]) * PW'(cell_scale_r);
        q_r[k]    <= QW'((PW'(pos_r[k]) * PW'(cell_scale_r)) >> (2 * F));
        rem_r[k]  <= '0;
      end else if (state_r == tsc_pkg::ST_MOD) begin
        q_r[k]   <= q_r[k] << 1;
        rem_r[k] <= (rem_step[k] >= (NW+1)'(n_eff)) ? NW'(rem_step[k] - (NW+1)'(n_eff))
                                                    : NW'(rem_step[k]);
        wlo_r[k] <= WW'(rsq[k] >> (F + 1));
        whi_r[k] <= WW'(fsq[k] >> (F + 1));
      end
    end
  end

  // Neighbor cells and weights of each axis
  always_ff @(posedge clk) begin
    if (state_r == tsc_pkg::ST_CELLS) begin
      wx_r[0] <= wlo_r[0];
      wx_r[2] <= whi_r[0];
      wx_r[1] <= WW'(1 << F) - wlo_r[0] - whi_r[0];
      wy_r[0] <= wlo_r[1];
      wy_r[2] <= whi_r[1];
      wy_r[1] <= WW'(1 << F) - wlo_r[1] - whi_r[1];
      wz_r[0] <= wlo_r[2];
      wz_r[2] <= whi_r[2];
      wz_r[1] <= WW'(1 << F) - wlo_r[2] - whi_r[2];
      cx_r[1] <= CW'(rem_r[0]);
      cy_r[1] <= CW'(rem_r[1]);
      cz_r[1] <= CW'(rem_r[2]);
      cx_r[0] <= (rem_r[0] == '0) ? CW'(n_eff - 1'b1) : CW'(rem_r[0] - 1'b1);
      cy_r[0] <= (rem_r[1] == '0) ? CW'(n_eff - 1'b1) : CW'(rem_r[1] - 1'b1);
      cz_r[0] <= (rem_r[2] == '0) ? CW'(n_eff - 1'b1) : CW'(rem_r[2] - 1'b1);
      cx_r[2] <= (rem_r[0] == n_eff - 1'b1) ? '0 : CW'(rem_r[0] + 1'b1);
      cy_r[2] <= (rem_r[1] == n_eff - 1'b1) ? '0 : CW'(rem_r[1] + 1'b1);
      cz_r[2] <= (rem_r[2] == n_eff - 1'b1) ? '0 : CW'(rem_r[2] + 1'b1);
    end
  end

  // Weight product pipeline: wx*wy, then *wz, then *mass alongside the store read
  assign issue_addr = AW'(cx_r[a_r]) * AW'(GRID_MAX * GRID_MAX)
                    + AW'(cy_r[b_r]) * AW'(GRID_MAX) + AW'(cz_r[c_r]);
  assign m1 = wx_r[a_r] * wy_r[b_r];
  assign m2 = wxy_r * wz1_r;
  assign m3 = mass_r * wxyz_r;
  assign sum = SUM_W'(ram_rdata) + SUM_W'(add_r);

  always_ff @(posedge clk) begin
    wxy_r   <= WW'(m1 >> F);
    wz1_r   <= wz_r[c_r];
    addr1_r <= issue_addr;
    wxyz_r  <= WW'(m2 >> F);
    addr2_r <= addr1_r;
    add_r   <= ADD_W'(m3 >> F);
    addr3_r <= addr2_r;
  end

  // Store port muxing: clear sweep, deposit write-back, read-and-clear
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr3_r;
    ram_wdata = '0;
    ram_raddr = addr2_r;
    if (state_r == tsc_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r[AW-1:0];
    end else if (v3_r) begin
      ram_we    = 1'b1;
      ram_wdata = (sum > SUM_W'(tsc_pkg::DENS_MAX)) ? tsc_pkg::DENS_MAX
                                                     : sum[tsc_pkg::DENS_W-1:0];
    end else if (state_r == tsc_pkg::ST_RD_DATA) begin
      ram_we    = out_free && cidx_ok && (kind_r == tsc_pkg::KIND_READ_CLR);
      ram_waddr = cidx_ext[AW-1:0];
    end
    if (state_r == tsc_pkg::ST_RD_ISSUE || state_r == tsc_pkg::ST_RD_DATA) begin
      ram_raddr = cidx_ext[AW-1:0];
    end
  end

  tsc_ram #(
    .WIDTH (tsc_pkg::DENS_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == tsc_pkg::ST_RD_DATA && out_free) begin
      out_density_r <= cidx_ok ? ram_rdata : '0;
      out_ovf_r     <= flag_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.density    = out_density_r;
  assign out_ch.overflowed = out_ovf_r;

  // Checks
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tsc_pkg::ST_RD_DATA))
    else $error("result raised outside a read");
  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |=> flag_r)
    else $error("overflow flag dropped");
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_r != 2'd3 && b_r != 2'd3 && c_r != 2'd3)
    else $error("neighborhood counter out of range");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsc_pkg::ST_IDLE) |-> !ram_we)
    else $error("store written while idle");
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsc_pkg::ST_IDLE) |-> (!v1_r && !v2_r && !v3_r))
    else $error("update pipeline busy while idle");

endmodule

// ===== src/tsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tsc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== verif/tsc_mass_assignment_3d_test.sv =====
// Self-checking testbench of the TSC mass assignment block, with its density predictor.
`timescale 1ns / 1ps

import tsc_pkg::*;

typedef struct {
  logic [DENS_W-1:0] density;
  logic              overflowed;
} cell_read_t;

class tsc_density_board;
  logic [GS_W-1:0]    grid_size;
  logic [SCALE_W-1:0] cell_scale;
  logic [MASS_W-1:0]  particle_mass;
  logic [DENS_W-1:0]  cells[int];
  bit                 ovf_sticky;
  cell_read_t         pending_reads[$];
  int                 errors;
  int                 last_center;

  function new();
    grid_size     = GS_RST;
    cell_scale    = SCALE_RST;
    particle_mass = MASS_RST;
    ovf_sticky    = 0;
    errors        = 0;
    last_center   = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_GRID_SIZE:  grid_size = data[GS_W-1:0];
      REG_CELL_SCALE: cell_scale = data;
      REG_PART_MASS:  particle_mass = data[MASS_W-1:0];
      default: ;
    endcase
  endfunction

  // Cells and quadratic weights of one axis.
  function void axis_weights(input logic [POS_W-1:0] pos, input int n,
                             output int cl[3], output bit [63:0] w[3]);
    bit [63:0] g, i, f, r;
    g = ({32'b0, pos} * {32'b0, cell_scale}) >> 16;
    i = (g >> 16) % n;
    f = {48'b0, g[15:0]};
    r = 64'd65536 - f;
    w[0] = (r * r) >> 17;
    w[2] = (f * f) >> 17;
    w[1] = 64'd65536 - w[0] - w[2];
    cl[0] = (int'(i) + n - 1) % n;
    cl[1] = int'(i);
    cl[2] = (int'(i) + 1) % n;
  endfunction

  // Note one accepted input transaction and update the predicted store.
  function void note_input(kind_t kind, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                           logic [POS_W-1:0] pz, logic [CIDX_W-1:0] cidx);
    int        n, idx;
    int        cx[3], cy[3], cz[3];
    bit [63:0] wx[3], wy[3], wz[3];
    bit [63:0] wxy, wxyz, add, v;
    cell_read_t rd;
    case (kind)
      KIND_DEPOSIT: begin
        n = grid_size;
        if (n < GS_MIN) n = GS_MIN;
        if (n > 64) n = 64;
        axis_weights(px, n, cx, wx);
        axis_weights(py, n, cy, wy);
        axis_weights(pz, n, cz, wz);
        for (int c = 0; c < 3; c++)
          for (int b = 0; b < 3; b++)
            for (int a = 0; a < 3; a++) begin
              wxy  = (wx[a] * wy[b]) >> 16;
              wxyz = (wxy * wz[c]) >> 16;
              add  = ({40'b0, particle_mass} * wxyz) >> 16;
              idx  = (cx[a] * 64 + cy[b]) * 64 + cz[c];
              v = (cells.exists(idx) ? {24'b0, cells[idx]} : 64'd0) + add;
              if (v > {24'b0, DENS_MAX}) begin
                v = {24'b0, DENS_MAX};
                ovf_sticky = 1;
              end
              cells[idx] = v[DENS_W-1:0];
            end
        last_center = (cx[1] * 64 + cy[1]) * 64 + cz[1];
      end
      KIND_READ, KIND_READ_CLR: begin
        rd.density = cells.exists(int'(cidx)) ? cells[int'(cidx)] : '0;
        rd.overflowed = ovf_sticky;
        if (kind == KIND_READ_CLR) cells.delete(int'(cidx));
        pending_reads.push_back(rd);
      end
      default: ;
    endcase
  endfunction

  // Compare one result transaction with the oldest expected read.
  function void check_result(logic [DENS_W-1:0] density, logic overflowed);
    cell_read_t rd;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected result density=%h overflowed=%b", $time, density, overflowed);
      errors++;
      return;
    end
    rd = pending_reads.pop_front();
    if (density !== rd.density) begin
      $display("%0t: density expected %h actual %h", $time, rd.density, density);
      errors++;
    end
    if (overflowed !== rd.overflowed) begin
      $display("%0t: overflowed expected %b actual %b", $time, rd.overflowed, overflowed);
      errors++;
    end
  endfunction
endclass

module tsc_mass_assignment_3d_test;
  localparam int STALL_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 0;
  logic rst_n;

  tsc_in_if  in_ch();
  tsc_out_if out_ch();
  tsc_cfg_if cfg_ch();

  tsc_mass_assignment_3d i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  tsc_density_board board = new();
  int   idle_cycles = 0;
  int   burst_left = 0;
  int   recent_cells[$];
  logic [15:0] stall_pattern = 16'hffff;
  int   pattern_age = 0;

  always #4 clk = ~clk;

  // Stall the result channel on a rotating pattern, reshuffled now and then.
  always @(posedge clk) begin
    pattern_age <= pattern_age + 1;
    if (pattern_age % 64 == 63) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern <= 16'hffff;
        1:       stall_pattern <= 16'h0001;
        default: stall_pattern <= 16'($urandom);
      endcase
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    out_ch.ready <= stall_pattern[15];
  end

  // Check results as they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.density, out_ch.overflowed);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tsc_mass_assignment_3d_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
    cfg_ch.valid <= 0;
  endtask

  // Send one transaction; the sender may pause between bursts.
  task automatic send_item(kind_t kind, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                           logic [POS_W-1:0] pz, logic [CIDX_W-1:0] cidx);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid      <= 1;
    in_ch.kind       <= kind;
    in_ch.pos_x      <= px;
    in_ch.pos_y      <= py;
    in_ch.pos_z      <= pz;
    in_ch.cell_index <= cidx;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(kind, px, py, pz, cidx);
    if (kind == KIND_DEPOSIT) begin
      recent_cells.push_back(board.last_center);
      if (recent_cells.size() > 32) void'(recent_cells.pop_front());
    end
  endtask

  // Hold the sender until all reads are back and the last deposit has drained.
  task automatic settle();
    in_ch.valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_phase(logic [CFG_DAT_W-1:0] gs, logic [CFG_DAT_W-1:0] scale,
                           logic [CFG_DAT_W-1:0] mass);
    write_reg(REG_GRID_SIZE, gs);
    write_reg(REG_CELL_SCALE, scale);
    write_reg(REG_PART_MASS, mass);
  endtask

  // Random transactions: mostly deposits and reads near recent deposits.
  task automatic random_items(int count);
    int          pick, base;
    logic [CIDX_W-1:0] cidx;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (recent_cells.size() != 0 && $urandom_range(0, 3) != 0) begin
        base = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
        cidx = CIDX_W'(base + $urandom_range(0, 2) * 4096 - 4096 + $urandom_range(0, 2) - 1);
      end else begin
        cidx = CIDX_W'($urandom);
      end
      if (pick < 50)
        send_item(KIND_DEPOSIT, $urandom, $urandom, $urandom, cidx);
      else if (pick < 75)
        send_item(KIND_READ, $urandom, $urandom, $urandom, cidx);
      else if (pick < 95)
        send_item(KIND_READ_CLR, $urandom, $urandom, $urandom, cidx);
      else
        send_item(KIND_NONE, $urandom, $urandom, $urandom, cidx);
    end
  endtask

  initial begin
    rst_n            <= 0;
    in_ch.valid      <= 0;
    in_ch.kind       <= KIND_DEPOSIT;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.pos_z      <= '0;
    in_ch.cell_index <= '0;
    cfg_ch.valid     <= 0;
    cfg_ch.index     <= REG_GRID_SIZE;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: default registers, position extremes, every kind.
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_DEPOSIT, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 18'h3ffff);
    send_item(KIND_DEPOSIT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
    send_item(KIND_DEPOSIT, 32'h00008000, 32'h0001c000, 32'h00024000, 0);
    send_item(KIND_NONE, 32'h12345678, 0, 0, 0);
    send_item(KIND_READ_CLR, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ_CLR, 0, 0, 0, 18'h3ffff);
    send_item(KIND_READ, 0, 0, 0, 18'h3ffff);
    send_item(KIND_READ, 0, 0, 0, 18'h01041);
    settle();

    // Grid below the minimum and zero scale, with zero mass and then the largest mass.
    set_phase(0, 0, 0);
    send_item(KIND_DEPOSIT, 32'hffffffff, 32'h55555555, 32'haaaaaaaa, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    settle();
    set_phase(1, 0, 24'hffffff);
    send_item(KIND_DEPOSIT, 32'hdeadbeef, 32'h1, 32'hffffffff, 0);
    send_item(KIND_DEPOSIT, 32'h0, 32'h0, 32'h0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 18'h02082);
    send_item(KIND_READ_CLR, 0, 0, 0, 18'h3f000);
    settle();

    // Random phases across register settings, extremes among them.
    set_phase(64, 32'h00010000, 24'h010000);
    random_items(75);
    settle();
    set_phase(3, 1, 24'hffffff);
    random_items(75);
    settle();
    set_phase(127, 32'hffffffff, 24'h000001);
    random_items(75);
    settle();
    set_phase(2, 32'h00080000, 24'h7fffff);
    random_items(75);
    settle();
    set_phase(65, 32'($urandom), 24'($urandom));
    random_items(75);
    settle();
    set_phase($urandom_range(3, 16), 32'($urandom_range(1, 32'h00100000)), 24'($urandom));
    random_items(75);
    settle();

    if (board.errors == 0 && board.pending_reads.size() == 0) begin
      $display("tsc_mass_assignment_3d_test: done, clean");
    end else begin
      $display("tsc_mass_assignment_3d_test: done, errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/tsc_pkg.sv
src/tsc_if.sv
src/tsc_ram.sv
src/tsc_mass_assignment_3d.sv
verif/tsc_mass_assignment_3d_test.sv
